// ===== rtl/rc_serial_frame_decoder_unit_defines.svh =====
// Assertion helpers for the frame decoder.
`ifndef RC_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH
`define RC_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCSFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsfd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsfd: next-cycle check failed");

`endif

// ===== rtl/rcsfd_pkg.sv =====
package rcsfd_pkg;

    localparam int PAIRS_PER_FRAME_DEF = 7;
    localparam int FRAME_BYTES = 16;
    localparam int TABLE_SLOTS = 8;
    localparam logic [7:0] GAP_RESET = 8'd10;
    localparam logic signed [10:0] SLOT_RESET = 11'sd88;
    localparam logic signed [11:0] VALUE_OFFSET = 12'sd512;
    localparam logic signed [11:0] LIMIT_POS = 12'sd1000;
    localparam logic signed [11:0] LIMIT_NEG = -12'sd1000;
    localparam logic [7:0] CHAN_MASK = 8'b0011_1100;
    localparam logic [7:0] VHI_MASK = 8'b0000_0011;
    localparam logic [3:0] MAX_CHANNEL = 4'd7;
    localparam logic [7:0] IDLE_MAX = 8'd255;
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam logic REG_GAP_MS = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RHI,
        S_RLO,
        S_DEC,
        S_ERD,
        S_EWAIT
    } state_t;

endpackage

// ===== rtl/rc_serial_frame_decoder_unit.sv =====
// Serial frame decoder for remote-control receivers.
// Input channel (in_valid/in_stall, command, data_byte): each transaction is a
// received byte (command 0) or a one-millisecond tick (command 1). A byte opens
// a frame only after gap_ms ticks of idle time; the first byte after reset only
// restarts the idle timer. The sixteenth byte of a frame starts decoding.
// Output channel (out_valid/out_stall): after each complete frame the eight
// channel slots are sent in ascending order, last high on slot 7, with
// frame_accepted low when a pair carried a channel number above 7.
// Ticks and ordinary bytes are taken without a stall. The closing byte of a
// frame starts a pass that reads the frame store twice and writes the table
// once per pair (S_RHI, S_RLO, S_DEC), stopping at a pair with a channel
// above 7, and then reads the table and loads the output register per slot
// (S_ERD, S_EWAIT); in_stall is high throughout. When the receiver stalls,
// the output register holds its transaction and the emission pauses; after the
// last slot is loaded the block takes input again while it waits to be taken.
// Reset empties the frame, clears the idle timer and sets every slot to 88.
// gap_ms sits at byte address 0 of the APB port and resets to 10.
module rc_serial_frame_decoder_unit #(
    parameter int PAIRS_PER_FRAME = rcsfd_pkg::PAIRS_PER_FRAME_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         channel_index,
    output logic signed [10:0] channel_value,
    output logic               frame_accepted,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rcsfd_pkg::*;

    `include "rc_serial_frame_decoder_unit_defines.svh"

    localparam int PAIR_W = $clog2(PAIRS_PER_FRAME + 1);

    state_t state_reg, state_next;

    logic [7:0]        gap_reg;
    logic [3:0]        count_reg, count_next;
    logic [7:0]        idle_reg, idle_next;
    logic              first_reg, first_next;
    logic              ok_reg, ok_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [2:0]        slot_reg, slot_next;
    logic [7:0]        hi_reg, hi_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_index_reg, out_index_next;
    logic signed [10:0] out_value_reg, out_value_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_last_reg, out_last_next;

    // Frame store: one write and one read port, registered read.
    logic [7:0] fs_mem [FRAME_BYTES];
    logic       fs_we, fs_re;
    logic [3:0] fs_waddr, fs_raddr;
    logic [7:0] fs_rdata_reg;

    // Channel table with a valid bit per slot standing in for the reset value.
    logic signed [10:0] tb_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] tb_valid_reg;
    logic               tb_we, tb_re;
    logic [2:0]         tb_waddr, tb_raddr;
    logic signed [10:0] tb_wdata;
    logic signed [10:0] tb_rdata_reg;
    logic               tb_rvalid_reg;
    logic signed [10:0] tb_value;

    logic              in_acc, out_take, cfg_wr;
    logic [7:0]        idle_eff;
    logic [2:0]        pair_p1;
    logic [3:0]        hi_addr, lo_addr;
    logic [3:0]        dec_ch;
    logic [9:0]        dec_v;
    logic signed [11:0] dec_off, dec_s, dec_clamp;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_take = !out_valid_reg || !out_stall;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_GAP_MS) ? {24'd0, gap_reg} : 32'd0;

    assign out_valid      = out_valid_reg;
    assign channel_index  = out_index_reg;
    assign channel_value  = out_value_reg;
    assign frame_accepted = out_ok_reg;
    assign last           = out_last_reg;

    assign idle_eff = first_reg ? idle_reg : 8'd0;
    assign pair_p1  = 3'(pair_reg) + 3'd1;
    assign hi_addr  = {pair_p1, 1'b0};
    assign lo_addr  = {pair_p1, 1'b1};

    assign dec_ch    = 4'((hi_reg & CHAN_MASK) >> 2);
    assign dec_v     = {hi_reg[1:0] & VHI_MASK[1:0], fs_rdata_reg};
    assign dec_off   = $signed({2'b00, dec_v}) - VALUE_OFFSET;
    assign dec_s     = dec_off <<< 1;
    assign dec_clamp = (dec_s > LIMIT_POS) ? LIMIT_POS :
                       (dec_s < LIMIT_NEG) ? LIMIT_NEG : dec_s;

    assign tb_value = tb_rvalid_reg ? tb_rdata_reg : SLOT_RESET;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idle_next      = idle_reg;
        first_next     = first_reg;
        ok_next        = ok_reg;
        pair_next      = pair_reg;
        slot_next      = slot_reg;
        hi_next        = hi_reg;
        fs_we          = 1'b0;
        fs_waddr       = count_reg;
        fs_re          = 1'b0;
        fs_raddr       = hi_addr;
        tb_we          = 1'b0;
        tb_waddr       = dec_ch[2:0];
        tb_wdata       = 11'(dec_clamp);
        tb_re          = 1'b0;
        tb_raddr       = slot_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (command == CMD_TICK)
                    begin
                        if (idle_reg != IDLE_MAX)
                        begin
                            idle_next = idle_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        first_next = 1'b1;
                        idle_next  = idle_eff;
                        if (count_reg == 4'd0)
                        begin
                            if (idle_eff >= gap_reg)
                            begin
                                fs_we      = 1'b1;
                                count_next = 4'd1;
                            end
                        end
                        else
                        begin
                            fs_we = 1'b1;
                            if (count_reg == 4'(FRAME_BYTES - 1))
                            begin
                                count_next = 4'd0;
                                idle_next  = 8'd0;
                                ok_next    = 1'b1;
                                pair_next  = '0;
                                state_next = S_RHI;
                            end
                            else
                            begin
                                count_next = count_reg + 4'd1;
                            end
                        end
                    end
                end
            end
            S_RHI:
            begin
                fs_re      = 1'b1;
                fs_raddr   = hi_addr;
                state_next = S_RLO;
            end
            S_RLO:
            begin
                hi_next    = fs_rdata_reg;
                fs_re      = 1'b1;
                fs_raddr   = lo_addr;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (dec_ch > MAX_CHANNEL)
                begin
                    ok_next    = 1'b0;
                    slot_next  = 3'd0;
                    state_next = S_ERD;
                end
                else
                begin
                    tb_we = 1'b1;
                    if (pair_reg == PAIR_W'(PAIRS_PER_FRAME - 1))
                    begin
                        slot_next  = 3'd0;
                        state_next = S_ERD;
                    end
                    else
                    begin
                        pair_next  = pair_reg + PAIR_W'(1);
                        state_next = S_RHI;
                    end
                end
            end
            S_ERD:
            begin
                tb_re      = 1'b1;
                tb_raddr   = slot_reg;
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = slot_reg;
                    out_value_next = tb_value;
                    out_ok_next    = ok_reg;
                    out_last_next  = (slot_reg == 3'(TABLE_SLOTS - 1));
                    if (slot_reg == 3'(TABLE_SLOTS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 3'd1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= GAP_RESET;
            count_reg     <= 4'd0;
            idle_reg      <= 8'd0;
            first_reg     <= 1'b0;
            ok_reg        <= 1'b1;
            pair_reg      <= '0;
            slot_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            tb_valid_reg  <= '0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == REG_GAP_MS)
            begin
                gap_reg <= pwdata[7:0];
            end
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            first_reg     <= first_next;
            ok_reg        <= ok_next;
            pair_reg      <= pair_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            if (tb_we)
            begin
                tb_valid_reg[tb_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg        <= hi_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[fs_waddr] <= data_byte;
        end
        if (fs_re)
        begin
            fs_rdata_reg <= fs_mem[fs_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tb_we)
        begin
            tb_mem[tb_waddr] <= tb_wdata;
        end
        if (tb_re)
        begin
            tb_rdata_reg  <= tb_mem[tb_raddr];
            tb_rvalid_reg <= tb_valid_reg[tb_raddr];
        end
    end

    // The closing byte of a frame must start the decode pass.
    `RCSFD_ASSERT_NEXT(a_frame_starts_decode,
        in_acc && command == CMD_BYTE && count_reg == 4'(FRAME_BYTES - 1),
        state_reg == S_RHI)
    // The slot flagged last is always slot 7.
    `RCSFD_ASSERT_SAME(a_last_is_top_slot, out_valid_reg && out_last_reg,
        out_index_reg == 3'(TABLE_SLOTS - 1))
    // With the output register free, a waiting slot is loaded at once.
    `RCSFD_ASSERT_NEXT(a_emit_loads, state_reg == S_EWAIT && !out_valid_reg,
        out_valid_reg)

endmodule

// ===== tb/sv/rc_serial_frame_decoder_unit_chk.sv =====
`timescale 1ns / 100ps

module rc_serial_frame_decoder_unit_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               command,
    input  logic [7:0]         data_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         channel_index,
    input  logic signed [10:0] channel_value,
    input  logic               frame_accepted,
    input  logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 slots_waiting,
    output int                 frames_seen,
    output int                 frames_rejected
);
    import rcsfd_pkg::*;

    localparam logic [2:0] GAP_ADDR = 3'(4 * int'(REG_GAP_MS));

    typedef struct packed {
        logic [2:0]         index;
        logic signed [10:0] value;
        logic               accepted;
        logic               final_slot;
    } slot_t;

    slot_t              slots_due[$];
    logic [7:0]         gap_ms;
    logic [7:0]         idle_ms;
    logic [3:0]         byte_count;
    logic               byte_seen;
    logic [7:0]         frame_bytes[FRAME_BYTES];
    logic signed [10:0] chan_table[TABLE_SLOTS];
    int                 fail_count;
    int                 frame_count;
    int                 reject_count;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    // Walks the pairs of the stored frame into the channel table and stops at
    // the first pair whose channel number does not fit the table.
    task automatic decode_frame_into_table(output logic ok);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] vhi;
        logic [3:0] ch;
        int         scaled;
        ok = 1'b1;
        for (int p = 1; p <= PAIRS_PER_FRAME_DEF && p <= 7; p++)
        begin
            if (ok)
            begin
                hi = frame_bytes[(2 * p) % FRAME_BYTES];
                lo = frame_bytes[(2 * p + 1) % FRAME_BYTES];
                ch = 4'((hi & CHAN_MASK) >> 2);
                vhi = hi & VHI_MASK;
                if (ch > MAX_CHANNEL)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    scaled = (int'({vhi[1:0], lo}) - int'(VALUE_OFFSET)) * 2;
                    if (scaled > int'(LIMIT_POS))
                        scaled = int'(LIMIT_POS);
                    if (scaled < int'(LIMIT_NEG))
                        scaled = int'(LIMIT_NEG);
                    chan_table[ch[2:0]] = 11'(scaled);
                end
            end
        end
    endtask

    task automatic take_item(input logic cmd, input logic [7:0] b);
        logic  ok;
        slot_t s;
        if (cmd == CMD_TICK)
        begin
            if (idle_ms != IDLE_MAX)
                idle_ms = idle_ms + 8'd1;
        end
        else
        begin
            if (!byte_seen)
            begin
                idle_ms = 8'd0;
                byte_seen = 1'b1;
            end
            if (byte_count == 4'd0)
            begin
                // A byte that arrives too soon after the last frame is dropped.
                if (idle_ms >= gap_ms)
                begin
                    frame_bytes[0] = b;
                    byte_count = 4'd1;
                end
            end
            else
            begin
                frame_bytes[byte_count] = b;
                if (byte_count == 4'(FRAME_BYTES - 1))
                begin
                    idle_ms = 8'd0;
                    byte_count = 4'd0;
                    decode_frame_into_table(ok);
                    frame_count++;
                    if (!ok)
                        reject_count++;
                    for (int k = 0; k < TABLE_SLOTS; k++)
                    begin
                        s.index = 3'(k);
                        s.value = chan_table[k];
                        s.accepted = ok;
                        s.final_slot = (k == TABLE_SLOTS - 1);
                        slots_due.push_back(s);
                    end
                end
                else
                begin
                    byte_count = byte_count + 4'd1;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slot_t got;
        slot_t want;
        if (!rst_n)
        begin
            slots_due.delete();
            gap_ms = GAP_RESET;
            idle_ms = 8'd0;
            byte_count = 4'd0;
            byte_seen = 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_bytes[i] = 8'd0;
            for (int i = 0; i < TABLE_SLOTS; i++)
                chan_table[i] = SLOT_RESET;
            fail_count = 0;
            frame_count = 0;
            reject_count = 0;
        end
        else
        begin
            // Results are compared before this edge's input is taken, since a
            // result can never belong to a transaction accepted at the same edge.
            if (out_valid && !out_stall)
            begin
                got = {channel_index, channel_value, frame_accepted, last};
                if (slots_due.size() == 0)
                begin
                    note_failure($sformatf(
                        "unexpected slot: index %0d value %0d accepted %0b last %0b",
                        got.index, $signed(got.value), got.accepted, got.final_slot));
                end
                else
                begin
                    want = slots_due.pop_front();
                    if (got !== want)
                        note_failure($sformatf(
                            {"slot mismatch: expected index %0d value %0d accepted %0b ",
                             "last %0b, got index %0d value %0d accepted %0b last %0b"},
                            want.index, $signed(want.value), want.accepted,
                            want.final_slot, got.index, $signed(got.value),
                            got.accepted, got.final_slot));
                end
            end
            if (in_valid && !in_stall)
                take_item(command, data_byte);
            if (psel && penable && pready && paddr == GAP_ADDR)
            begin
                if (pwrite)
                    gap_ms = pwdata[7:0];
                else if (prdata !== {24'd0, gap_ms})
                    note_failure($sformatf("gap_ms read: expected %0d, got %0d",
                                           gap_ms, prdata));
            end
        end
        mismatches <= fail_count;
        slots_waiting <= slots_due.size();
        frames_seen <= frame_count;
        frames_rejected <= reject_count;
    end

endmodule

// ===== tb/sv/rc_serial_frame_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

module rc_serial_frame_decoder_unit_tb;
    import rcsfd_pkg::*;

    localparam int         CYCLE_LIMIT = 500000;
    localparam logic [2:0] GAP_ADDR = 3'(4 * int'(REG_GAP_MS));

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic [7:0]         data_byte;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         channel_index;
    logic signed [10:0] channel_value;
    logic               frame_accepted;
    logic               last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int                 mismatches;
    int                 slots_waiting;
    int                 frames_seen;
    int                 frames_rejected;
    int                 items_sent;
    int                 cycle_count = 0;
    int                 stall_hold = 0;
    logic               gaps_on;
    logic               stalls_on;
    logic [7:0]         gap_now;
    logic [7:0]         mid_gap;

    rc_serial_frame_decoder_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .channel_index  (channel_index),
        .channel_value  (channel_value),
        .frame_accepted (frame_accepted),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    rc_serial_frame_decoder_unit_chk u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .channel_index   (channel_index),
        .channel_value   (channel_value),
        .frame_accepted  (frame_accepted),
        .last            (last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .slots_waiting   (slots_waiting),
        .frames_seen     (frames_seen),
        .frames_rejected (frames_rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d slots outstanding",
                     cycle_count, slots_waiting);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver stalls: runs of random length, mostly short, now and then long.
    always @(posedge clk)
    begin
        if (!stalls_on)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60)
                                                       : $urandom_range(0, 3);
        end
    end

    // Leaves in_valid high on return, unless it inserted an idle gap, so that a
    // following transaction can go out back to back; anything that waits must lower it first.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic send_pair(input logic [3:0] ch, input logic [9:0] v);
        send_item(CMD_BYTE, {2'($urandom), ch, v[9:8]});
        send_item(CMD_BYTE, v[7:0]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (slots_waiting != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= GAP_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_gap(input logic [7:0] g);
        settle();
        apb_access(1'b1, {24'd0, g});
        apb_access(1'b0, 32'd0);
        gap_now = g;
    endtask

    // A frame preceded by enough idle ticks, sometimes with a byte that comes
    // one tick too early, and sometimes with a pair whose channel is out of range.
    task automatic send_random_frame();
        int         ticks;
        int         bad_pair;
        logic [9:0] v;
        bad_pair = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        ticks = gap_now + $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0)
        begin
            repeat (int'(gap_now) - 1)
                send_item(CMD_TICK, 8'($urandom));
            send_item(CMD_BYTE, 8'($urandom));
            ticks = 1;
        end
        repeat (ticks)
            send_item(CMD_TICK, 8'($urandom));
        send_item(CMD_BYTE, 8'($urandom));
        send_item(CMD_BYTE, 8'($urandom));
        for (int p = 1; p <= 7; p++)
        begin
            case ($urandom_range(0, 7))
                0: v = 10'd0;
                1: v = 10'd1023;
                2: v = 10'($urandom_range(0, 12));
                3: v = 10'($urandom_range(1011, 1023));
                default: v = 10'($urandom);
            endcase
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_TICK, 8'($urandom));
            send_pair((p == bad_pair) ? 4'($urandom_range(8, 15))
                                      : 4'($urandom_range(0, 7)), v);
        end
    endtask

    task automatic random_run(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom), 8'($urandom));
            end
            else
            begin
                send_random_frame();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_BYTE;
        data_byte = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        items_sent = 0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        gap_now = GAP_RESET;
        mid_gap = 8'd0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        set_gap(8'd2);
        // The first byte after reset only restarts the idle timer, and a byte
        // with one tick of idle time is still too early for a gap of two.
        send_item(CMD_BYTE, 8'hA5);
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_BYTE, 8'h3C);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        // Both ends of the value range, inside and beyond the clamp; slot 6 is
        // left at its reset value.
        send_pair(4'd0, 10'd0);
        send_pair(4'd7, 10'd1023);
        send_pair(4'd3, 10'd512);
        send_pair(4'd1, 10'd11);
        send_pair(4'd2, 10'd1013);
        send_pair(4'd4, 10'd12);
        send_pair(4'd5, 10'd1012);

        gaps_on = 1'b1;
        stalls_on = 1'b1;
        settle();
        random_run(60);

        // A stretch with no idling on either side.
        mid_gap = 8'($urandom_range(3, 20));
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        set_gap(mid_gap);
        random_run(55);

        gaps_on = 1'b1;
        stalls_on = 1'b1;
        set_gap(8'd1);
        random_run(70);

        settle();
        $display("Checked %0d decoded frames (%0d with a bad channel) over %0d input transactions",
                 frames_seen, frames_rejected, items_sent);
        $display("Gap settings 2, %0d and 1, with and without idle cycles on both sides",
                 mid_gap);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
